/* hdl/sos_pkg.sv */
package sos_pkg;

	localparam int FREQ_W   = 24;
	localparam int SAMPLE_W = 16;
	localparam int RATE_W   = 18;
	localparam int SPAN_W   = 25;
	localparam int POS_W    = 32;
	localparam int STEP_W   = 6;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int REG_W  = 1;

	localparam logic [REG_W-1:0] REG_SAMPLE_RATE = 1'b0;

	localparam logic [6:0]        HUNDREDTHS = 7'd100;
	localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
	localparam logic [SPAN_W-1:0] SPAN_RESET = 25'd4410000;

	// quotient bits per pass of the divider
	localparam logic [STEP_W-1:0] STEPS_PERIOD = 6'(SPAN_W);
	localparam logic [STEP_W-1:0] STEPS_PHASE  = 6'(POS_W);
	localparam logic [STEP_W-1:0] STEPS_SCALE  = 6'(SAMPLE_W);

	typedef struct packed {
		logic [SPAN_W-1:0] r_init;
		logic [POS_W-1:0]  d_init;
		logic [SPAN_W-1:0] divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

/* hdl/sos_if.sv */
interface sos_freq_if;
	import sos_pkg::*;
	logic              valid;
	logic              ready;
	logic [FREQ_W-1:0] frequency;

	modport source (output valid, output frequency, input ready);
	modport sink   (input valid, input frequency, output ready);
endinterface

interface sos_sample_if;
	import sos_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

/* hdl/sawtooth_oscillator_sample.sv */
// sawtooth oscillator: each frequency beat (hundredths of a hertz) yields one signed 16-bit
// saw sample, the phase of a running 32-bit sample position within a period of
// sample_rate*100/frequency samples, scaled to 16 bits and centred on zero; the position
// steps by one on every beat and wraps. frequency zero, or a frequency above sample_rate*100,
// gives a sample of 0. all arithmetic runs through one shared restoring divider that
// retires one quotient bit per cycle: period (25 bits), position mod period (32 bits) and
// phase scaling (16 bits), each pass followed by a handover. ready stays low from acceptance
// until the sample moves to the output register, so no new beat is taken while the divider
// works on one; frequency zero skips the divider, a period that truncates to zero skips the
// later passes, and a full output register stalls the handover. a finished sample waits in an
// output register so the next frequency beat can be taken while it is held. sample_rate sits at byte
// address 0 of the apb port, resets to 44100 and is read back on prdata; write it only
// while idle.
module sawtooth_oscillator_sample
	import sos_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	sos_freq_if.sink          freq_ch,
	sos_sample_if.source      sample_ch
);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV_A = 3'd1;  // period = span / frequency
	localparam logic [2:0] ST_DIV_B = 3'd2;  // phase = position mod period
	localparam logic [2:0] ST_DIV_C = 3'd3;  // scaled = phase * 65536 / period
	localparam logic [2:0] ST_PUSH  = 3'd4;  // hand result to output register

	logic [2:0]          state_q;
	logic [SPAN_W-1:0]   span;
	logic [SPAN_W-1:0]   period_q;
	logic [POS_W-1:0]    pos_q;
	logic [SAMPLE_W-1:0] res_q;
	logic [SAMPLE_W-1:0] out_q;
	logic                out_valid_q;

	logic              accept;
	logic              slot_free;
	logic              push_fire;
	logic              div_start;
	div_req_t          div_req;
	div_sts_t          div_sts;
	logic [POS_W-1:0]  div_quot;
	logic [SPAN_W-1:0] div_rem;
	logic              period_zero;

	sos_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.span    (span)
	);

	sos_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.sts    (div_sts),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// handshakes
	assign freq_ch.ready = (state_q == ST_IDLE);
	assign accept        = freq_ch.valid && freq_ch.ready;
	assign slot_free     = !out_valid_q || sample_ch.ready;
	assign push_fire     = (state_q == ST_PUSH) && slot_free;
	assign period_zero   = (div_quot[SPAN_W-1:0] == '0);

	assign sample_ch.valid  = out_valid_q;
	assign sample_ch.sample = out_q;

	// divider launches, one per pass
	always_comb begin
		div_start = 1'b0;
		div_req   = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (freq_ch.frequency != '0)) begin
					div_start      = 1'b1;
					div_req.d_init = {span, (POS_W-SPAN_W)'(0)};
					div_req.divisor = SPAN_W'(freq_ch.frequency);
					div_req.steps  = STEPS_PERIOD;
				end
			end
			ST_DIV_A: begin
				if (div_sts.done && !period_zero) begin
					div_start       = 1'b1;
					div_req.d_init  = pos_q;
					div_req.divisor = div_quot[SPAN_W-1:0];
					div_req.steps   = STEPS_PHASE;
				end
			end
			ST_DIV_B: begin
				// remainder below period is already a valid partial remainder
				if (div_sts.done) begin
					div_start       = 1'b1;
					div_req.r_init  = div_rem;
					div_req.divisor = period_q;
					div_req.steps   = STEPS_SCALE;
				end
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (freq_ch.frequency == '0) ? ST_PUSH : ST_DIV_A;
					end
				end
				ST_DIV_A: begin
					if (div_sts.done) begin
						state_q <= period_zero ? ST_PUSH : ST_DIV_B;
					end
				end
				ST_DIV_B: begin
					if (div_sts.done) begin
						state_q <= ST_DIV_C;
					end
				end
				ST_DIV_C: begin
					if (div_sts.done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
						pos_q   <= pos_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (push_fire) begin
				out_valid_q <= 1'b1;
			end else if (sample_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_A && div_sts.done) begin
			period_q <= div_quot[SPAN_W-1:0];
		end
		if (accept && (freq_ch.frequency == '0)) begin
			res_q <= '0;
		end else if (state_q == ST_DIV_A && div_sts.done && period_zero) begin
			res_q <= '0;
		end else if (state_q == ST_DIV_C && div_sts.done) begin
			// subtract half scale by flipping the top bit
			res_q <= {~div_quot[SAMPLE_W-1], div_quot[SAMPLE_W-2:0]};
		end
		if (push_fire) begin
			out_q <= res_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_sts.busy)
		else $error("beat accepted while divider busy");

	a_done_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == ST_DIV_A || state_q == ST_DIV_B || state_q == ST_DIV_C))
		else $error("divider finished outside a divide state");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_sts.busy)
		else $error("divider did not start");

	a_zero_freq_push: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (freq_ch.frequency == '0) |=> (state_q == ST_PUSH))
		else $error("zero frequency not sent straight to output");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push_fire |=> sample_ch.valid && (sample_ch.sample == $past(res_q)))
		else $error("result lost on its way to output register");
`endif

endmodule

/* hdl/sos_cfg.sv */
module sos_cfg
	import sos_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [SPAN_W-1:0] span
);

	logic [RATE_W-1:0] rate_q;
	logic [SPAN_W-1:0] span_q;
	logic              wr_rate;

	assign pready  = 1'b1;
	assign wr_rate = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_SAMPLE_RATE);

	// span kept ready as rate times one hundred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			span_q <= SPAN_RESET;
		end else if (wr_rate) begin
			rate_q <= pwdata[RATE_W-1:0];
			span_q <= SPAN_W'(pwdata[RATE_W-1:0]) * SPAN_W'(HUNDREDTHS);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[APB_AW-1:2] == REG_SAMPLE_RATE) begin
			prdata = APB_DW'(rate_q);
		end
	end

	assign span = span_q;

endmodule

/* hdl/sos_div.sv */
module sos_div
	import sos_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  div_req_t          req,
	output div_sts_t          sts,
	output logic [POS_W-1:0]  quot,
	output logic [SPAN_W-1:0] rem
);

	logic [SPAN_W-1:0] r_q;
	logic [POS_W-1:0]  d_q;
	logic [SPAN_W-1:0] div_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [SPAN_W:0] trial;
	logic [SPAN_W:0] diff;
	logic            ge;

	// restoring step: one quotient bit a cycle
	assign trial = {r_q, d_q[POS_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= req.r_init;
			d_q   <= req.d_init;
			div_q <= req.divisor;
		end else if (busy_q) begin
			r_q <= ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
			d_q <= {d_q[POS_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = d_q;
	assign rem      = r_q;

endmodule
